@@ hw/rtl/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg
// shared widths, codes, segment structs and pixel helpers for the
// run-length sprite segment decoder
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int MAX_DIM    = 2048;
    localparam int PAL_SIZE   = 256;
    localparam int MIN_WIDTH  = 8;

    localparam int DIM_W      = 12;
    localparam int COL_W      = $clog2(MAX_DIM);
    localparam int ROW_W      = $clog2(MAX_DIM);
    localparam int LG_W       = $clog2(COL_W + 1);
    localparam int PIX_W      = 2 * COL_W + 1;
    localparam int ADDR_W     = 22;
    localparam int RUN_W      = 8;
    localparam int VAL_W      = 32;
    localparam int COLOR_W    = 16;
    localparam int IDX_W      = $clog2(PAL_SIZE);
    localparam int MODE_W     = 2;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PAL   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [RUN_W-1:0] n;
        logic [DIM_W-1:0] w;
        logic [LG_W-1:0]  lg;
    } seg_ctx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DIM_W-1:0]  len;
        logic [COL_W-1:0]  col_next;
        logic [ROW_W-1:0]  row_next;
        logic [RUN_W-1:0]  n_next;
        logic              last;
    } seg_res_t;

    function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
        logic [DIM_W-1:0] r;
        r = w;
        if (w < DIM_W'(MIN_WIDTH))
            r = DIM_W'(MIN_WIDTH);
        else if (w > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
        logic [DIM_W-1:0] r;
        r = (h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h;
        return r;
    endfunction

    // log2 of the padded row pitch
    function automatic logic [LG_W-1:0] pitch_shift(input logic [DIM_W-1:0] w);
        logic [LG_W-1:0] lg;
        lg = '0;
        for (int i = 0; i < DIM_W; i++)
        begin
            if ((DIM_W'(1) << i) < w)
                lg = LG_W'(i + 1);
        end
        return lg;
    endfunction

    function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] r;
        r = (row == ROW_W'(MAX_DIM - 1)) ? '0 : row + ROW_W'(1);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] expand_1555(input logic [COLOR_W-1:0] v);
        logic [VAL_W-1:0] o;
        o = {{8{v[15]}}, v[4:0], 3'b000, v[9:5], 3'b000, v[14:10], 3'b000};
        return o;
    endfunction

    function automatic logic [VAL_W-1:0] swap_rb(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] o;
        o = {v[31:24], v[7:0], v[15:8], v[23:16]};
        return o;
    endfunction

endpackage

@@ hw/rtl/rsd_ram.sv @@
// ----------------------------------------------------------------------------
// rsd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/rsd_seg_unit.sv @@
// ----------------------------------------------------------------------------
// rsd_seg_unit
// shared segment step: row wrap, room left in row, clamp of the run,
// padded address and next position
// ----------------------------------------------------------------------------
module rsd_seg_unit
    import rsd_pkg::*;
(
    input  seg_ctx_t ctx,
    output seg_res_t res
);

    logic             wrap;
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] row0;
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] n_ext;
    logic [DIM_W-1:0] len;
    logic [DIM_W-1:0] col_sum;

    always_comb
    begin
        wrap    = {1'b0, ctx.col} >= ctx.w;
        col0    = wrap ? '0 : ctx.col;
        row0    = wrap ? row_step(ctx.row) : ctx.row;
        room    = ctx.w - {1'b0, col0};
        n_ext   = DIM_W'(ctx.n);
        len     = (n_ext < room) ? n_ext : room;
        col_sum = {1'b0, col0} + len;

        res.addr   = (ADDR_W'(row0) << ctx.lg) + ADDR_W'(col0);
        res.len    = len;
        res.n_next = ctx.n - len[RUN_W-1:0];
        res.last   = (res.n_next == '0);
        if (col_sum == ctx.w)
        begin
            res.col_next = '0;
            res.row_next = row_step(row0);
        end
        else
        begin
            res.col_next = col_sum[COL_W-1:0];
            res.row_next = row0;
        end
    end

endmodule

@@ hw/rtl/rle_sprite_segment_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rle_sprite_segment_decoder_unit
// run-length sprite decoder: palette writes, image start and runs split
// into row segments of a power-of-two pitch texture
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | req_type palette_index palette_color      | in_valid/in_ready
//          | run_length run_value                      |
//  out     | seg_address seg_length seg_value          | out_valid/out_ready
//          | seg_last image_done                       |
//  cfg     | cfg_index cfg_data                        | cfg_write_en
//
//  palette write, start and empty runs complete on acceptance, in idle.
//  a run is accepted, then split into row segments in turn by the
//  shared segment unit; ready returns once its last segment is registered.
//  output stalls hold the segment loop; the palette valid bits clear at reset.
// ----------------------------------------------------------------------------
module rle_sprite_segment_decoder_unit
    import rsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [IDX_W-1:0]     palette_index,
    input  logic [COLOR_W-1:0]   palette_color,
    input  logic [RUN_W-1:0]     run_length,
    input  logic [VAL_W-1:0]     run_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    seg_address,
    output logic [DIM_W-1:0]     seg_length,
    output logic [VAL_W-1:0]     seg_value,
    output logic                 seg_last,
    output logic                 image_done,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEG  = 1'b1;

    logic                  state_reg, state_next;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [PAL_SIZE-1:0]   pal_valid_reg;
    logic                  pal_hit_reg;
    logic [PIX_W-1:0]      pixels_left_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [RUN_W-1:0]      n_reg;
    logic [VAL_W-1:0]      value_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DIM_W-1:0]      len_reg;
    logic [VAL_W-1:0]      seg_value_reg;
    logic                  last_reg;
    logic                  done_reg;

    logic                  in_fire;
    logic                  run_fire;
    logic                  out_load;
    logic [DIM_W-1:0]      w_eff;
    logic [2*DIM_W-1:0]    pix_total;
    logic [RUN_W-1:0]      n_clamp;
    logic [VAL_W-1:0]      pal_rdata;
    logic [VAL_W-1:0]      pix_value;
    seg_ctx_t              ctx;
    seg_res_t              res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign w_eff     = eff_width(width_reg);
    assign pix_total = {{DIM_W{1'b0}}, w_eff} * {{DIM_W{1'b0}}, eff_height(height_reg)};
    assign n_clamp   = (PIX_W'(run_length) > pixels_left_reg)
                       ? pixels_left_reg[RUN_W-1:0] : run_length;
    assign run_fire  = in_fire && (req_type == REQ_RUN) && (n_clamp != '0);
    assign out_load  = (state_reg == ST_SEG) && (!out_valid_reg || out_ready);

    rsd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PAL_SIZE)
    ) u_palette (
        .clk   (clk),
        .we    (in_fire && (req_type == REQ_PAL)),
        .waddr (palette_index),
        .wdata (expand_1555(palette_color)),
        .re    (run_fire),
        .raddr (run_value[IDX_W-1:0]),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        ctx.col = col_reg;
        ctx.row = row_reg;
        ctx.n   = n_reg;
        ctx.w   = w_eff;
        ctx.lg  = pitch_shift(w_eff);
    end

    rsd_seg_unit u_seg (
        .ctx (ctx),
        .res (res)
    );

    always_comb
    begin
        case (mode_reg)
            MODE_PAL:    pix_value = pal_hit_reg ? pal_rdata : '0;
            MODE_DIRECT: pix_value = swap_rb(value_reg);
            default:     pix_value = {{(VAL_W-8){1'b0}}, value_reg[7:0]};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (run_fire)
            state_next = ST_SEG;
        else if (out_load && res.last)
            state_next = ST_IDLE;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            width_reg       <= DIM_W'(MIN_WIDTH);
            height_reg      <= DIM_W'(1);
            mode_reg        <= MODE_RAW;
            pal_valid_reg   <= '0;
            pixels_left_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                    default:    ;
                endcase
            end

            if (in_fire && (req_type == REQ_PAL))
                pal_valid_reg[palette_index] <= 1'b1;

            if (in_fire && (req_type == REQ_START))
            begin
                pixels_left_reg <= pix_total[PIX_W-1:0];
                col_reg         <= '0;
                row_reg         <= '0;
            end
            else if (run_fire)
                pixels_left_reg <= pixels_left_reg - PIX_W'(n_clamp);

            if (out_load)
            begin
                col_reg <= res.col_next;
                row_reg <= res.row_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (run_fire)
        begin
            n_reg       <= n_clamp;
            value_reg   <= run_value;
            pal_hit_reg <= pal_valid_reg[run_value[IDX_W-1:0]];
        end
        else if (out_load)
            n_reg <= res.n_next;

        if (out_load)
        begin
            addr_reg      <= res.addr;
            len_reg       <= res.len;
            seg_value_reg <= pix_value;
            last_reg      <= res.last;
            done_reg      <= res.last && (pixels_left_reg == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign seg_address = addr_reg;
    assign seg_length  = len_reg;
    assign seg_value   = seg_value_reg;
    assign seg_last    = last_reg;
    assign image_done  = done_reg;

endmodule
